// File: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the textured wall column span
// Field widths, operation codes, stream packing offsets and the texture
// memory request that passes between the sequencer and the texture store.
// ----------------------------------------------------------------------------
package tws_pkg;

    // Texture geometry.
    localparam int MAX_TEX_SIZE = 64;
    localparam int TEX_BITS     = $clog2(MAX_TEX_SIZE);
    localparam int FACE_W       = 2;
    localparam int ADDR_W       = FACE_W + 2 * TEX_BITS;

    // Field and register widths.
    localparam int SCR_CFG_W    = 13;
    localparam int TEX_CFG_W    = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int HEIGHT_W     = 16;
    localparam int FRAC_W       = 16;
    localparam int ROW_W        = 12;
    localparam int COLOR_W      = 32;
    localparam int OP_W         = 2;

    localparam logic [SCR_CFG_W-1:0] SCREEN_LIMIT = SCR_CFG_W'(4096);

    // Serial multiplier: a 17-bit multiplicand (one more bit than the
    // fraction, so that the mirrored value 1.0 fits) by a texture size.
    localparam int MCAND_W      = FRAC_W + 1;
    localparam int MUL_W        = MCAND_W + TEX_CFG_W;
    localparam int MUL_STEPS    = TEX_CFG_W;
    localparam int MUL_CNT_W    = $clog2(MUL_STEPS);

    // Restoring divider: the quotient is a texel row, below MAX_TEX_SIZE.
    localparam int DIV_STEPS    = TEX_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // Operation codes carried in the input tuser.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd2;

    // Input tdata layout, lowest bit first.
    localparam int IN_FACE_LSB   = 0;
    localparam int IN_U_LSB      = IN_FACE_LSB + FACE_W;
    localparam int IN_V_LSB      = IN_U_LSB + TEX_BITS;
    localparam int IN_COLOR_LSB  = IN_V_LSB + TEX_BITS;
    localparam int IN_HEIGHT_LSB = IN_COLOR_LSB + COLOR_W;
    localparam int IN_FRAC_LSB   = IN_HEIGHT_LSB + HEIGHT_W;
    localparam int IN_COL_LSB    = IN_FRAC_LSB + FRAC_W;
    localparam int IN_ROW_LSB    = IN_COL_LSB + ROW_W;
    localparam int IN_BITS       = IN_ROW_LSB + ROW_W;
    localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_X_LSB     = 0;
    localparam int OUT_Y_LSB     = OUT_X_LSB + ROW_W;
    localparam int OUT_COLOR_LSB = OUT_Y_LSB + ROW_W;
    localparam int OUT_BITS      = OUT_COLOR_LSB + COLOR_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // One access to the texture store: a write or a read, never both.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] wdata;
    } t_tex_req;

    // Saturate a texture size register into 1 .. MAX_TEX_SIZE.
    function automatic logic [TEX_CFG_W-1:0] clamp_tex(input logic [TEX_CFG_W-1:0] v);
        logic [TEX_CFG_W-1:0] r;
        if (v == '0) begin
            r = TEX_CFG_W'(1);
        end else if (v > TEX_CFG_W'(MAX_TEX_SIZE)) begin
            r = TEX_CFG_W'(MAX_TEX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/tws_mul.sv
// ----------------------------------------------------------------------------
// tws_mul: bit-serial shift-and-add multiplier
// Takes one multiplier bit per cycle, least significant first, and adds the
// shifted multiplicand when the bit is set. Pulses o_done with the product.
// ----------------------------------------------------------------------------
module tws_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tws_pkg::MCAND_W-1:0]      i_mcand,
    input  logic [tws_pkg::TEX_CFG_W-1:0]    i_mplier,
    output logic                             o_done,
    output logic [tws_pkg::MUL_W-1:0]        o_product
);

    logic                            r_busy;
    logic                            r_done;
    logic [tws_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [tws_pkg::MUL_W-1:0]       r_acc;
    logic [tws_pkg::MUL_W-1:0]       r_mcand;
    logic [tws_pkg::TEX_CFG_W-1:0]   r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tws_pkg::MUL_CNT_W'(tws_pkg::MUL_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= tws_pkg::MUL_W'(i_mcand);
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: rtl/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div: restoring divider for the texel row
// Produces one quotient bit per cycle. The dividend is known to be below
// divisor times MAX_TEX_SIZE, so its upper part seeds the partial remainder
// and only the low TEX_BITS dividend bits are shifted in.
// ----------------------------------------------------------------------------
module tws_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tws_pkg::MUL_W-1:0]        i_dividend,
    input  logic [tws_pkg::HEIGHT_W-1:0]     i_divisor,
    output logic                             o_done,
    output logic [tws_pkg::TEX_BITS-1:0]     o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [tws_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [tws_pkg::HEIGHT_W-1:0]    r_rem;
    logic [tws_pkg::TEX_BITS-1:0]    r_low;
    logic [tws_pkg::TEX_BITS-1:0]    r_quot;
    logic [tws_pkg::HEIGHT_W+1:0]    trial;

    // Shift the next dividend bit into the remainder and try the subtraction.
    assign trial = {1'b0, r_rem, r_low[tws_pkg::TEX_BITS-1]} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tws_pkg::DIV_CNT_W'(tws_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[tws_pkg::TEX_BITS +: tws_pkg::HEIGHT_W];
            r_low  <= i_dividend[tws_pkg::TEX_BITS-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_low <= r_low << 1;
            if (!trial[tws_pkg::HEIGHT_W+1]) begin
                r_rem  <= trial[tws_pkg::HEIGHT_W-1:0];
                r_quot <= {r_quot[tws_pkg::TEX_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[tws_pkg::HEIGHT_W-2:0], r_low[tws_pkg::TEX_BITS-1]};
                r_quot <= {r_quot[tws_pkg::TEX_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// File: rtl/tws_tex_mem.sv
// ----------------------------------------------------------------------------
// tws_tex_mem: texture store
// Single-port memory of four faces of texels, addressed {face, u, v}.
// Read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module tws_tex_mem (
    input  logic                           i_clk,
    input  tws_pkg::t_tex_req              i_req,
    output logic [tws_pkg::COLOR_W-1:0]    o_rd_data
);

    localparam int DEPTH = 2 ** tws_pkg::ADDR_W;

    logic [tws_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [tws_pkg::COLOR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/textured_wall_column_span.sv
// ----------------------------------------------------------------------------
// textured_wall_column_span: textured wall column renderer
// Draws one screen column of a textured wall, one pixel per step item, from
// a four-face texture store that is loaded texel by texel.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream with the operation in tuser: a write item
// stores one texel and leaves the block idle; a start item latches the
// face, wall height, column and first row, and finds the texel column with
// the bit-serial multiplier; a step item emits one pixel and goes through
// the serial multiplier (one bit of tex_height per cycle), the restoring
// divider (one texel row bit per cycle) and, after both of them, a
// read of the texture memory. One item is worked on at a time; the finished
// pixel sits in an output register, so the next item is taken while the pixel
// waits for the master side. Start and write items, steps outside an active
// span and the unused operation code give no output item. The texture store
// is not cleared at reset and has no clearing pass; a texel must be written
// before any pixel reads it. Configuration writes are plain register writes,
// meant to be made while the block is idle.
// ----------------------------------------------------------------------------
module textured_wall_column_span (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    // Configuration: index 0 screen_height, 1 tex_width, 2 tex_height.
    input  logic                               i_cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tws_pkg::SCR_CFG_W-1:0]      i_cfg_data,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, lowest bit up: face, texel_u, texel_v, texel_color, wall_height,
    // hit_fraction, column, start_row, zero fill.
    input  logic [tws_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: operation.
    input  logic [tws_pkg::OP_W-1:0]           s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, lowest bit up: pixel_x, pixel_y, color.
    output logic [tws_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tlast: last pixel of the column.
    output logic                               m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_READ,
        S_OUT
    } t_state;

    // Configuration registers, kept as written and saturated where used.
    logic [tws_pkg::SCR_CFG_W-1:0] r_screen_height;
    logic [tws_pkg::TEX_CFG_W-1:0] r_tex_width;
    logic [tws_pkg::TEX_CFG_W-1:0] r_tex_height;

    // Sequencer and span state.
    t_state                        r_state, n_state;
    logic                          r_is_start, n_is_start;
    logic                          r_span_active, n_span_active;
    logic [tws_pkg::HEIGHT_W-1:0]  r_wall_row, n_wall_row;
    logic [tws_pkg::ROW_W-1:0]     r_screen_row, n_screen_row;
    logic [tws_pkg::HEIGHT_W-1:0]  r_span_height, n_span_height;
    logic [tws_pkg::TEX_BITS-1:0]  r_tex_column, n_tex_column;
    logic [tws_pkg::FACE_W-1:0]    r_active_face, n_active_face;
    logic [tws_pkg::ROW_W-1:0]     r_draw_column, n_draw_column;

    // Output register.
    logic                            r_out_valid, n_out_valid;
    logic [tws_pkg::OUT_DATA_W-1:0]  r_out_data, n_out_data;
    logic                            r_out_last, n_out_last;

    // Input fields.
    logic [tws_pkg::FACE_W-1:0]    in_face;
    logic [tws_pkg::TEX_BITS-1:0]  in_u;
    logic [tws_pkg::TEX_BITS-1:0]  in_v;
    logic [tws_pkg::COLOR_W-1:0]   in_color;
    logic [tws_pkg::HEIGHT_W-1:0]  in_height;
    logic [tws_pkg::FRAC_W-1:0]    in_frac;
    logic [tws_pkg::ROW_W-1:0]     in_column;
    logic [tws_pkg::ROW_W-1:0]     in_start_row;

    logic                          accept;
    logic                          out_free;
    logic [tws_pkg::TEX_CFG_W-1:0] tex_w;
    logic [tws_pkg::TEX_CFG_W-1:0] tex_h;
    logic [tws_pkg::SCR_CFG_W-1:0] rows;
    logic [tws_pkg::HEIGHT_W-1:0]  rows_wide;
    logic [tws_pkg::MCAND_W-1:0]   frac_used;
    logic [tws_pkg::TEX_CFG_W-1:0] col_raw;
    logic [tws_pkg::TEX_CFG_W-1:0] col_sel;
    logic [tws_pkg::HEIGHT_W:0]    wall_next;
    logic [tws_pkg::ROW_W:0]       screen_next;
    logic                          step_done;

    // Arithmetic units and memory.
    logic                          mul_start;
    logic [tws_pkg::MCAND_W-1:0]   mul_mcand;
    logic [tws_pkg::TEX_CFG_W-1:0] mul_mplier;
    logic                          mul_done;
    logic [tws_pkg::MUL_W-1:0]     mul_product;
    logic                          div_start;
    logic                          div_done;
    logic [tws_pkg::TEX_BITS-1:0]  div_quotient;
    tws_pkg::t_tex_req             tex_req;
    logic [tws_pkg::COLOR_W-1:0]   tex_rd_data;

    assign in_face      = s_axis_tdata[tws_pkg::IN_FACE_LSB +: tws_pkg::FACE_W];
    assign in_u         = s_axis_tdata[tws_pkg::IN_U_LSB +: tws_pkg::TEX_BITS];
    assign in_v         = s_axis_tdata[tws_pkg::IN_V_LSB +: tws_pkg::TEX_BITS];
    assign in_color     = s_axis_tdata[tws_pkg::IN_COLOR_LSB +: tws_pkg::COLOR_W];
    assign in_height    = s_axis_tdata[tws_pkg::IN_HEIGHT_LSB +: tws_pkg::HEIGHT_W];
    assign in_frac      = s_axis_tdata[tws_pkg::IN_FRAC_LSB +: tws_pkg::FRAC_W];
    assign in_column    = s_axis_tdata[tws_pkg::IN_COL_LSB +: tws_pkg::ROW_W];
    assign in_start_row = s_axis_tdata[tws_pkg::IN_ROW_LSB +: tws_pkg::ROW_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign tex_w     = tws_pkg::clamp_tex(r_tex_width);
    assign tex_h     = tws_pkg::clamp_tex(r_tex_height);
    assign rows      = (r_screen_height > tws_pkg::SCREEN_LIMIT) ? tws_pkg::SCREEN_LIMIT
                                                                 : r_screen_height;
    assign rows_wide = tws_pkg::HEIGHT_W'(rows);

    // South and west faces are mirrored: the multiplicand becomes 1.0 minus
    // the fraction, which needs the one extra bit of the multiplicand.
    assign frac_used = in_face[0] ? (tws_pkg::MCAND_W'(1) << tws_pkg::FRAC_W)
                                    - tws_pkg::MCAND_W'(in_frac)
                                  : tws_pkg::MCAND_W'(in_frac);

    // Texel column is the integer part of the product; the mirrored case can
    // reach the full width and is clamped to the last texel.
    assign col_raw = mul_product[tws_pkg::FRAC_W +: tws_pkg::TEX_CFG_W];
    assign col_sel = (col_raw >= tex_w) ? tex_w - 1'b1 : col_raw;

    assign wall_next   = {1'b0, r_wall_row} + 1'b1;
    assign screen_next = {1'b0, r_screen_row} + 1'b1;
    assign step_done   = (wall_next >= {1'b0, r_span_height})
                      || (screen_next >= rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= tws_pkg::SCR_CFG_W'(480);
            r_tex_width     <= tws_pkg::TEX_CFG_W'(64);
            r_tex_height    <= tws_pkg::TEX_CFG_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tws_pkg::CFG_SCREEN_HEIGHT: begin
                    r_screen_height <= i_cfg_data;
                end
                tws_pkg::CFG_TEX_WIDTH: begin
                    r_tex_width <= i_cfg_data[tws_pkg::TEX_CFG_W-1:0];
                end
                tws_pkg::CFG_TEX_HEIGHT: begin
                    r_tex_height <= i_cfg_data[tws_pkg::TEX_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state       = r_state;
        n_is_start    = r_is_start;
        n_span_active = r_span_active;
        n_wall_row    = r_wall_row;
        n_screen_row  = r_screen_row;
        n_span_height = r_span_height;
        n_tex_column  = r_tex_column;
        n_active_face = r_active_face;
        n_draw_column = r_draw_column;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;

        mul_start     = 1'b0;
        mul_mcand     = frac_used;
        mul_mplier    = tex_w;
        div_start     = 1'b0;

        tex_req.wr_en = 1'b0;
        tex_req.rd_en = 1'b0;
        tex_req.addr  = {r_active_face, r_tex_column, div_quotient};
        tex_req.wdata = in_color;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        tws_pkg::OP_WRITE: begin
                            tex_req.wr_en = 1'b1;
                            tex_req.addr  = {in_face, in_u, in_v};
                        end
                        tws_pkg::OP_START: begin
                            mul_start     = 1'b1;
                            n_is_start    = 1'b1;
                            n_state       = S_MUL;
                            n_active_face = in_face;
                            n_draw_column = in_column;
                            n_screen_row  = in_start_row;
                            n_span_height = in_height;
                            // A wall taller than the screen starts half of
                            // the excess rows into the wall.
                            n_wall_row    = (in_height > rows_wide)
                                          ? (in_height - rows_wide) >> 1
                                          : '0;
                            n_span_active = (in_height != '0)
                                         && ({1'b0, in_start_row} < rows);
                        end
                        tws_pkg::OP_STEP: begin
                            if (r_span_active) begin
                                mul_start  = 1'b1;
                                mul_mcand  = tws_pkg::MCAND_W'(r_wall_row);
                                mul_mplier = tex_h;
                                n_is_start = 1'b0;
                                n_state    = S_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    if (r_is_start) begin
                        n_tex_column = col_sel[tws_pkg::TEX_BITS-1:0];
                        n_state      = S_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                tex_req.rd_en = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = tws_pkg::OUT_DATA_W'({tex_rd_data, r_screen_row,
                                                        r_draw_column});
                    n_out_last  = step_done;
                    n_wall_row  = wall_next[tws_pkg::HEIGHT_W-1:0];
                    n_screen_row = screen_next[tws_pkg::ROW_W-1:0];
                    if (step_done) begin
                        n_span_active = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, span state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_is_start    <= 1'b0;
            r_span_active <= 1'b0;
            r_wall_row    <= '0;
            r_screen_row  <= '0;
            r_span_height <= '0;
            r_tex_column  <= '0;
            r_active_face <= '0;
            r_draw_column <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_is_start    <= n_is_start;
            r_span_active <= n_span_active;
            r_wall_row    <= n_wall_row;
            r_screen_row  <= n_screen_row;
            r_span_height <= n_span_height;
            r_tex_column  <= n_tex_column;
            r_active_face <= n_active_face;
            r_draw_column <= n_draw_column;
            r_out_valid   <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    tws_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    tws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_product),
        .i_divisor  (r_span_height),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    tws_tex_mem u_tex_mem (
        .i_clk     (i_clk),
        .i_req     (tex_req),
        .o_rd_data (tex_rd_data)
    );

endmodule

// File: bench/tb_textured_wall_column_span.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_textured_wall_column_span: self-checking bench for the wall column span
// Walks a short table of directed items and then drives random wall spans
// under several register settings. Every pixel is checked field by field
// against the pixel typed into its directed row or else against a predictor
// of the texture store, span and registers, while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_textured_wall_column_span;
    import tws_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_GAP  = 40;
    localparam int STORE_DEPTH = 4 * MAX_TEX_SIZE * MAX_TEX_SIZE;

    // The fourth operation code has no meaning; the block must ignore it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [FACE_W-1:0] {
        FACE_NORTH = 2'd0,
        FACE_SOUTH = 2'd1,
        FACE_EAST  = 2'd2,
        FACE_WEST  = 2'd3
    } t_face;

    // How a directed row is checked: by the predictor, as giving no pixel,
    // or against the pixel typed into the row.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } t_chk;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        t_face               face;
        logic [TEX_BITS-1:0] tex_u;
        logic [TEX_BITS-1:0] tex_v;
        logic [COLOR_W-1:0]  color;
        logic [HEIGHT_W-1:0] height;
        logic [FRAC_W-1:0]   frac;
        logic [ROW_W-1:0]    column;
        logic [ROW_W-1:0]    start_row;
    } t_span_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]   x;
        logic [ROW_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    typedef struct packed {
        t_chk      chk;
        t_span_cmd cmd;
        t_pixel    px;
    } t_dir_row;

    typedef struct packed {
        logic [SCR_CFG_W-1:0] scr;
        logic [SCR_CFG_W-1:0] tex_w;
        logic [SCR_CFG_W-1:0] tex_h;
        logic [2:0]           tx_max;
        logic [2:0]           rx_max;
        logic                 hold;
        logic [11:0]          items;
    } t_phase;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [SCR_CFG_W-1:0]   i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata, lowest bit up: face, texel_u, texel_v, texel_color, wall_height,
    // hit_fraction, column, start_row, zero fill.
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    // tuser: operation.
    logic [OP_W-1:0]        s_axis_tuser  = OP_STEP;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata, lowest bit up: pixel_x, pixel_y, color.
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;

    textured_wall_column_span dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor copy of the registers, the span state and the texture store.
    logic [SCR_CFG_W-1:0] cfg_screen = SCR_CFG_W'(480);
    logic [TEX_CFG_W-1:0] cfg_tex_w  = TEX_CFG_W'(64);
    logic [TEX_CFG_W-1:0] cfg_tex_h  = TEX_CFG_W'(64);
    logic [HEIGHT_W-1:0]  p_wall_row   = '0;
    logic [ROW_W-1:0]     p_screen_row = '0;
    logic [HEIGHT_W-1:0]  p_span_h     = '0;
    logic [TEX_BITS-1:0]  p_tex_col    = '0;
    t_face                p_face       = FACE_NORTH;
    logic [ROW_W-1:0]     p_column     = '0;
    bit                   p_active     = 1'b0;
    logic [COLOR_W-1:0]   texel_mem [STORE_DEPTH];
    // Marks the texels that have been written at least once.
    bit                   texel_set [STORE_DEPTH];

    t_pixel pending_pixels [$];
    int     error_count  = 0;
    int     cycle_count  = 0;
    int     tx_gap_max   = 0;
    int     rx_stall_max = 0;
    bit     rx_hold      = 1'b0;

    // Directed items, run with the register values left by reset.
    localparam int DIR_ROWS = 26;
    t_dir_row directed_tbl [DIR_ROWS] = '{
        // Step before any start: the block is idle and gives nothing.
        '{CHK_NONE,  '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        // Unused operation with every field at its top value.
        '{CHK_NONE,  '{OP_UNUSED, FACE_WEST, 6'h3F, 6'h3F, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                       12'hFFF, 12'hFFF}, '0},
        // One-row wall on the north face, rightmost column.
        '{CHK_MODEL, '{OP_WRITE, FACE_NORTH, 6'd0, 6'd0, 32'hDEADBEEF, 16'd0, 16'd0, 12'd0,
                       12'd0}, '0},
        '{CHK_MODEL, '{OP_START, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd1, 16'd0, 12'hFFF, 12'd0},
                     '0},
        '{CHK_PIXEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0},
                     '{12'hFFF, 12'd0, 32'hDEADBEEF, 1'b1}},
        '{CHK_NONE,  '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        // Mirrored face at fraction zero lands on the full width and is
        // clamped to the last texel column; the row is the last screen row.
        '{CHK_MODEL, '{OP_WRITE, FACE_SOUTH, 6'd63, 6'd0, 32'h12345678, 16'd0, 16'd0, 12'd0,
                       12'd0}, '0},
        '{CHK_MODEL, '{OP_START, FACE_SOUTH, 6'd0, 6'd0, 32'd0, 16'd1, 16'd0, 12'd0, 12'd479},
                     '0},
        '{CHK_PIXEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0},
                     '{12'd0, 12'd479, 32'h12345678, 1'b1}},
        // Tallest wall: half of the excess over the screen is skipped.
        '{CHK_MODEL, '{OP_START, FACE_EAST, 6'd0, 6'd0, 32'd0, 16'hFFFF, 16'hFFFF, 12'd2048,
                       12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        // Empty spans: zero height, then a first row below the screen.
        '{CHK_MODEL, '{OP_START, FACE_WEST, 6'd0, 6'd0, 32'd0, 16'd0, 16'h8000, 12'd5, 12'd5},
                     '0},
        '{CHK_NONE,  '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_START, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd10, 16'h1000, 12'd5,
                       12'd480}, '0},
        '{CHK_NONE,  '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        // Three-row wall, mirrored at the top fraction.
        '{CHK_MODEL, '{OP_START, FACE_WEST, 6'd0, 6'd0, 32'd0, 16'd3, 16'hFFFF, 12'd1, 12'd2},
                     '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        // A new start abandons a span that is still running.
        '{CHK_MODEL, '{OP_START, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd100, 16'h8000, 12'd7,
                       12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_START, FACE_SOUTH, 6'd0, 6'd0, 32'd0, 16'd2, 16'h1234, 12'd9,
                       12'd478}, '0},
        // A texel written in the middle of a span is seen by the next pixel.
        '{CHK_MODEL, '{OP_WRITE, FACE_SOUTH, 6'd59, 6'd0, 32'hA5A5A5A5, 16'd0, 16'd0, 12'd0,
                       12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0},
        '{CHK_MODEL, '{OP_STEP, FACE_NORTH, 6'd0, 6'd0, 32'd0, 16'd0, 16'd0, 12'd0, 12'd0}, '0}
    };

    // Register settings of the random part. Out-of-range values check the
    // saturation of every register; one phase runs with no idling at all.
    localparam int PHASES = 8;
    t_phase phases [PHASES] = '{
        '{13'd480,  13'd64,   13'd64,   3'd7, 3'd7, 1'b1, 12'd400},
        '{13'd1,    13'd1,    13'd1,    3'd7, 3'd7, 1'b0, 12'd200},
        '{13'd4096, 13'd63,   13'd17,   3'd0, 3'd0, 1'b0, 12'd250},
        '{13'd8191, 13'h1FFF, 13'd0,    3'd7, 3'd0, 1'b0, 12'd200},
        '{13'd0,    13'd0,    13'h1F85, 3'd0, 3'd7, 1'b0, 12'd100},
        '{13'd37,   13'd5,    13'd64,   3'd7, 3'd7, 1'b1, 12'd250},
        '{13'd200,  13'd13,   13'd7,    3'd3, 3'd7, 1'b0, 12'd300},
        '{13'd4095, 13'd64,   13'd1,    3'd7, 3'd7, 1'b0, 12'd150}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned screen_rows();
        return (cfg_screen > SCREEN_LIMIT) ? 32'(SCREEN_LIMIT) : 32'(cfg_screen);
    endfunction

    function automatic int unsigned sat_tex(input logic [TEX_CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > TEX_CFG_W'(MAX_TEX_SIZE))
            return MAX_TEX_SIZE;
        return 32'(v);
    endfunction

    // Applies one accepted item to the predictor state and reports the pixel
    // it produces, if any.
    function automatic bit next_wall_pixel(input t_span_cmd c, output t_pixel px);
        int unsigned rows;
        int unsigned w;
        int unsigned th;
        int unsigned col;
        int unsigned trow;
        int unsigned wr_next;
        int unsigned sr_next;
        bit          got;
        got  = 1'b0;
        px   = '0;
        rows = screen_rows();
        if (c.op == OP_WRITE) begin
            texel_mem[{c.face, c.tex_u, c.tex_v}] = c.color;
            texel_set[{c.face, c.tex_u, c.tex_v}] = 1'b1;
        end else if (c.op == OP_START) begin
            w = sat_tex(cfg_tex_w);
            if (c.face == FACE_SOUTH || c.face == FACE_WEST) begin
                // The mirrored column can reach the full width; keep it inside.
                col = ((32'd65536 - 32'(c.frac)) * w) >> 16;
                if (col > w - 1)
                    col = w - 1;
            end else begin
                col = (32'(c.frac) * w) >> 16;
            end
            p_face       = c.face;
            p_tex_col    = col[TEX_BITS-1:0];
            p_column     = c.column;
            p_screen_row = c.start_row;
            p_span_h     = c.height;
            if (32'(c.height) > rows)
                p_wall_row = HEIGHT_W'((32'(c.height) - rows) / 2);
            else
                p_wall_row = '0;
            p_active = (32'(p_wall_row) < 32'(c.height)) && (32'(c.start_row) < rows);
        end else if (c.op == OP_STEP && p_active) begin
            th       = sat_tex(cfg_tex_h);
            trow     = (32'(p_wall_row) * th) / 32'(p_span_h);
            px.x     = p_column;
            px.y     = p_screen_row;
            px.color = texel_mem[{p_face, p_tex_col, trow[TEX_BITS-1:0]}];
            wr_next  = 32'(p_wall_row) + 1;
            sr_next  = 32'(p_screen_row) + 1;
            px.last  = (wr_next >= 32'(p_span_h)) || (sr_next >= rows);
            if (px.last)
                p_active = 1'b0;
            p_wall_row   = wr_next[HEIGHT_W-1:0];
            p_screen_row = sr_next[ROW_W-1:0];
            got = 1'b1;
        end
        return got;
    endfunction

    // Offers one item after a random gap, waits for the handshake and then
    // records what the block must answer.
    task automatic push_item(input t_span_cmd c, input t_chk chk, input t_pixel typed);
        int unsigned          gap;
        logic [IN_DATA_W-1:0] word;
        t_pixel               px;
        bit                   has_px;
        gap  = $urandom_range(0, tx_gap_max);
        word = '0;
        word[IN_FACE_LSB   +: FACE_W]   = c.face;
        word[IN_U_LSB      +: TEX_BITS] = c.tex_u;
        word[IN_V_LSB      +: TEX_BITS] = c.tex_v;
        word[IN_COLOR_LSB  +: COLOR_W]  = c.color;
        word[IN_HEIGHT_LSB +: HEIGHT_W] = c.height;
        word[IN_FRAC_LSB   +: FRAC_W]   = c.frac;
        word[IN_COL_LSB    +: ROW_W]    = c.column;
        word[IN_ROW_LSB    +: ROW_W]    = c.start_row;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= c.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        has_px = next_wall_pixel(c, px);
        if (chk == CHK_PIXEL)
            pending_pixels.push_back(typed);
        else if (chk == CHK_MODEL && has_px)
            pending_pixels.push_back(px);
    endtask

    // Before a step, writes the texel that the step is going to read when it
    // has never been written, so that no pixel reads an unknown texel.
    task automatic cover_texel(output bit sent_one);
        t_span_cmd         c;
        int unsigned       th;
        int unsigned       trow;
        logic [ADDR_W-1:0] addr;
        sent_one = 1'b0;
        if (p_active) begin
            th   = sat_tex(cfg_tex_h);
            trow = (32'(p_wall_row) * th) / 32'(p_span_h);
            addr = {p_face, p_tex_col, trow[TEX_BITS-1:0]};
            if (!texel_set[addr]) begin
                c       = rand_cmd();
                c.op    = OP_WRITE;
                c.face  = p_face;
                c.tex_u = p_tex_col;
                c.tex_v = trow[TEX_BITS-1:0];
                push_item(c, CHK_MODEL, '0);
                sent_one = 1'b1;
            end
        end
    endtask

    // Stops offering items, waits for every expected pixel and lets a start
    // that is still being worked on finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // Writes the three registers on back-to-back cycles.
    task automatic load_config(input t_phase ph);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_data  <= ph.scr;
        @(posedge i_clk);
        i_cfg_index <= CFG_TEX_WIDTH;
        i_cfg_data  <= ph.tex_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_TEX_HEIGHT;
        i_cfg_data  <= ph.tex_h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_screen = ph.scr;
        cfg_tex_w  = ph.tex_w[TEX_CFG_W-1:0];
        cfg_tex_h  = ph.tex_h[TEX_CFG_W-1:0];
    endtask

    function automatic t_span_cmd rand_cmd();
        t_span_cmd c;
        c.op        = OP_UNUSED;
        c.face      = t_face'($urandom_range(0, 3));
        c.tex_u     = TEX_BITS'($urandom);
        c.tex_v     = TEX_BITS'($urandom);
        c.color     = $urandom;
        c.height    = HEIGHT_W'($urandom);
        c.frac      = FRAC_W'($urandom);
        c.column    = ROW_W'($urandom);
        c.start_row = ROW_W'($urandom);
        return c;
    endfunction

    // Mostly whole spans (a start followed by steps, now and then a texel
    // write in between), plus stray steps, plain writes and unused codes.
    task automatic random_traffic(input int unsigned budget);
        t_span_cmd   c;
        int unsigned rows;
        int unsigned pick;
        int unsigned lim;
        int unsigned steps;
        int unsigned sent;
        bit          extra;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            c    = rand_cmd();
            if (pick < 8) begin
                push_item(c, CHK_MODEL, '0);
                sent++;
            end else if (pick < 14) begin
                cover_texel(extra);
                sent += 32'(extra);
                c.op = OP_STEP;
                push_item(c, CHK_MODEL, '0);
                sent++;
            end else if (pick < 28) begin
                c.op = OP_WRITE;
                push_item(c, CHK_MODEL, '0);
                sent++;
            end else begin
                rows = screen_rows();
                c.op = OP_START;
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    c.frac = '0;
                else if (pick == 1)
                    c.frac = '1;
                // Wall height: empty, tallest, just over the screen, short,
                // medium or anything.
                pick = $urandom_range(0, 9);
                case (pick)
                    0: c.height = '0;
                    1: c.height = '1;
                    2, 3: c.height = HEIGHT_W'(rows + $urandom_range(0, 40));
                    4, 5, 6: c.height = HEIGHT_W'($urandom_range(1, 16));
                    7: c.height = HEIGHT_W'($urandom);
                    default: c.height = HEIGHT_W'($urandom_range(1, 300));
                endcase
                // First row: near the top, near the bottom, past it, or anything.
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    c.start_row = ROW_W'($urandom_range(0, 8));
                end else if (pick < 7 && rows > 0) begin
                    lim = (rows > 8) ? 8 : rows - 1;
                    c.start_row = ROW_W'(rows - 1 - $urandom_range(0, lim));
                end else if (pick == 7) begin
                    lim = rows + $urandom_range(0, 3);
                    c.start_row = (lim > 4095) ? ROW_W'(4095) : ROW_W'(lim);
                end
                push_item(c, CHK_MODEL, '0);
                sent++;
                steps = $urandom_range(1, 24);
                for (int k = 0; k < int'(steps) && sent < budget; k++) begin
                    c = rand_cmd();
                    if ($urandom_range(0, 99) < 8) begin
                        c.op = OP_WRITE;
                        push_item(c, CHK_MODEL, '0);
                        sent++;
                        c = rand_cmd();
                    end
                    cover_texel(extra);
                    sent += 32'(extra);
                    c.op = OP_STEP;
                    push_item(c, CHK_MODEL, '0);
                    sent++;
                end
            end
        end
    endtask

    // Pixel sink: random stalls per item, a long hold-off on request, and a
    // field-by-field check of every accepted pixel.
    initial begin : pixel_sink
        int unsigned stall;
        t_pixel      got;
        t_pixel      want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.x     = m_axis_tdata[OUT_X_LSB +: ROW_W];
            got.y     = m_axis_tdata[OUT_Y_LSB +: ROW_W];
            got.color = m_axis_tdata[OUT_COLOR_LSB +: COLOR_W];
            got.last  = m_axis_tlast;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d color=%h last=%0d",
                       got.x, got.y, got.color, got.last);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x) begin
                    $error("pixel_x mismatch: expected %0d, got %0d", want.x, got.x);
                    error_count++;
                end
                if (got.y !== want.y) begin
                    $error("pixel_y mismatch: expected %0d, got %0d", want.y, got.y);
                    error_count++;
                end
                if (got.color !== want.color) begin
                    $error("color mismatch: expected %h, got %h", want.color, got.color);
                    error_count++;
                end
                if (got.last !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d", want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        bit extra;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gap_max   = 7;
        rx_stall_max = 7;
        foreach (directed_tbl[i]) begin
            if (directed_tbl[i].cmd.op == OP_STEP)
                cover_texel(extra);
            push_item(directed_tbl[i].cmd, directed_tbl[i].chk, directed_tbl[i].px);
        end

        foreach (phases[p]) begin
            drain();
            load_config(phases[p]);
            tx_gap_max   = phases[p].tx_max;
            rx_stall_max = phases[p].rx_max;
            if (phases[p].hold)
                rx_hold = 1'b1;
            random_traffic(phases[p].items);
        end
        drain();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tws_pkg.sv
rtl/tws_mul.sv
rtl/tws_div.sv
rtl/tws_tex_mem.sv
rtl/textured_wall_column_span.sv
bench/tb_textured_wall_column_span.sv
